// ----- rtl/cwsh_pkg.sv -----
// ----------------------------------------------------------------------------
// cwsh_pkg: shared types and constants
// Request and result structs, cosine constants and command codes.
// ----------------------------------------------------------------------------
package cwsh_pkg;

    localparam int MAX_WAVES_DEF = 64;

    localparam int MUL_W  = 32;
    localparam int PROD_W = 64;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [26:0]        TWO_PI_Q24 = 27'd105414357;
    localparam logic signed [31:0] ONE_Q30    = 32'sd1073741824;
    localparam logic signed [31:0] C2_Q30     = -32'sd536870908;
    localparam logic signed [31:0] C4_Q30     = 32'sd44739216;
    localparam logic signed [31:0] C6_Q30     = -32'sd1491255;
    localparam logic signed [31:0] C8_Q30     = 32'sd26587;
    localparam logic signed [31:0] C10_Q30    = -32'sd280;

    localparam logic [2:0] HORNER_LAST = 3'd4;

    typedef struct packed {
        logic               command;
        logic [5:0]         wave_index;
        logic signed [31:0] amplitude;
        logic signed [31:0] wavenumber_x;
        logic signed [31:0] wavenumber_y;
        logic signed [31:0] phase_offset;
        logic signed [31:0] ref_x;
        logic signed [31:0] ref_y;
        logic signed [31:0] heading_sin;
        logic signed [31:0] heading_cos;
        logic signed [31:0] lateral_offset;
    } t_req;

    typedef struct packed {
        logic signed [31:0] elevation;
        logic               saturated;
    } t_res;

    typedef struct packed {
        logic signed [31:0] amplitude;
        logic signed [31:0] wavenumber_x;
        logic signed [31:0] wavenumber_y;
        logic signed [31:0] phase_offset;
    } t_wave;

    function automatic logic signed [31:0] horner_coef(input logic [2:0] idx);
        case (idx)
            3'd0:    return C8_Q30;
            3'd1:    return C6_Q30;
            3'd2:    return C4_Q30;
            3'd3:    return C2_Q30;
            default: return ONE_Q30;
        endcase
    endfunction

    function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
        if (v > 35'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -35'sh0_8000_0000) begin
            return -32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// ----- rtl/cosine_wave_sum_height.sv -----
// ----------------------------------------------------------------------------
// cosine_wave_sum_height: sum-of-cosines surface height
// A load request writes one table slot when wave_index is below MAX_WAVES; it gives no result.
// An evaluate request raises o_done once the N active waves are summed, N = active waves.
// Each wave walks one shared multiplier; range reduction uses a reciprocal multiply.
// busy drops as o_done rises; the result strobe lasts one cycle and cannot stall.
// Reset clears the sequencer and wave_count; the wave table is not cleared.
// ----------------------------------------------------------------------------
module cosine_wave_sum_height #(
    parameter int MAX_WAVES = cwsh_pkg::MAX_WAVES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  cwsh_pkg::t_req   i_req,
    output logic             busy,
    output logic             o_done,
    output cwsh_pkg::t_res   o_res,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [6:0]       i_cfg_data
);
    import cwsh_pkg::*;

    localparam int AW    = (MAX_WAVES > 1) ? $clog2(MAX_WAVES) : 1;
    localparam int CW    = $clog2(MAX_WAVES + 1);
    localparam int SUM_W = 34 + $clog2(MAX_WAVES);

    localparam logic [63:0] RECIP_WIDE = (64'd1 << 57) / {37'd0, TWO_PI_Q24};
    localparam logic signed [31:0] RECIP_Q57 = RECIP_WIDE[31:0];
    localparam logic signed [28:0] TWO_PI_R  = {2'b00, TWO_PI_Q24};
    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sh7FFF_FFFF);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-64'sh8000_0000);

    typedef enum logic [19:0] {
        S_IDLE  = 20'h00001,
        S_GX    = 20'h00002,
        S_GY    = 20'h00004,
        S_GEND  = 20'h00008,
        S_FETCH = 20'h00010,
        S_KX    = 20'h00020,
        S_KY    = 20'h00040,
        S_PH    = 20'h00080,
        S_QMUL  = 20'h00100,
        S_QT    = 20'h00200,
        S_RSUB  = 20'h00400,
        S_FIX   = 20'h00800,
        S_FOLD  = 20'h01000,
        S_SQ    = 20'h02000,
        S_Y2    = 20'h04000,
        S_HMUL  = 20'h08000,
        S_HADD  = 20'h10000,
        S_AMUL  = 20'h20000,
        S_ACC   = 20'h40000,
        S_SAT   = 20'h80000
    } t_state;

    t_state r_state, n_state;
    logic   r_done;
    logic [6:0] r_wave_count;

    t_wave r_mem [MAX_WAVES];
    t_wave r_mem_q;

    logic signed [31:0] r_ref_x, r_ref_y, r_sin, r_cos, r_lat;
    logic signed [31:0] r_gx, r_gy;
    logic [CW-1:0]      r_n, r_w;
    logic signed [47:0] r_argx;
    logic signed [50:0] r_arg;
    logic signed [28:0] r_rem;
    logic [26:0]        r_r;
    logic [28:0]        r_y2;
    logic signed [31:0] r_p;
    logic [2:0]         r_j;
    logic signed [SUM_W-1:0] r_sum;
    t_res               r_res;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rnd30, rnd24, rnd16;
    logic signed [33:0] term30;
    logic signed [34:0] gx_wide, gy_wide;
    logic signed [31:0] coef;
    logic signed [33:0] hsum;
    logic signed [50:0] rsub;
    logic [26:0]        rem;
    logic               accept, load_acc, wr_ok, cfg_wr;

    assign accept   = start && !busy;
    assign load_acc = accept && (i_req.command == CMD_LOAD);
    assign wr_ok    = $unsigned(32'(i_req.wave_index)) < $unsigned(32'(MAX_WAVES));
    assign cfg_wr   = i_cfg_valid && o_cfg_ready;

    cwsh_mul u_mul (
        .i_clk  (i_clk),
        .i_op_a (mul_a),
        .i_op_b (mul_b),
        .o_prod (prod)
    );

    always_comb begin
        unique case (r_state)
            S_GX: begin
                mul_a = r_lat;
                mul_b = r_sin;
            end
            S_GY: begin
                mul_a = r_lat;
                mul_b = r_cos;
            end
            S_KX: begin
                mul_a = r_mem_q.wavenumber_x;
                mul_b = r_gx;
            end
            S_KY: begin
                mul_a = r_mem_q.wavenumber_y;
                mul_b = r_gy;
            end
            S_QMUL: begin
                mul_a = r_arg[48:17];
                mul_b = RECIP_Q57;
            end
            S_QT: begin
                mul_a = {{8{prod[63]}}, prod[63:40]};
                mul_b = {5'd0, TWO_PI_Q24};
            end
            S_SQ: begin
                mul_a = {5'd0, r_r};
                mul_b = {5'd0, r_r};
            end
            S_HMUL: begin
                mul_a = {3'd0, r_y2};
                mul_b = r_p;
            end
            S_AMUL: begin
                mul_a = r_mem_q.amplitude;
                mul_b = r_p;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign rnd30   = (prod + (64'sd1 <<< 29)) >>> 30;
    assign rnd24   = (prod + (64'sd1 <<< 23)) >>> 24;
    assign rnd16   = (prod + (64'sd1 <<< 15)) >>> 16;
    assign term30  = rnd30[33:0];
    assign gx_wide = {{3{r_ref_x[31]}}, r_ref_x} - {term30[33], term30};
    assign gy_wide = {{3{r_ref_y[31]}}, r_ref_y} + {term30[33], term30};
    assign coef    = horner_coef(r_j);
    assign hsum    = rnd24[33:0] + {{2{coef[31]}}, coef};
    assign rsub    = r_arg - prod[50:0];
    assign rem     = r_rem[26:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept && (i_req.command == CMD_EVAL)) n_state = S_GX;
            S_GX:    n_state = S_GY;
            S_GY:    n_state = S_GEND;
            S_GEND:  n_state = (r_n == '0) ? S_SAT : S_FETCH;
            S_FETCH: n_state = S_KX;
            S_KX:    n_state = S_KY;
            S_KY:    n_state = S_PH;
            S_PH:    n_state = S_QMUL;
            S_QMUL:  n_state = S_QT;
            S_QT:    n_state = S_RSUB;
            S_RSUB:  n_state = S_FIX;
            S_FIX:   n_state = S_FOLD;
            S_FOLD:  n_state = S_SQ;
            S_SQ:    n_state = S_Y2;
            S_Y2:    n_state = S_HMUL;
            S_HMUL:  n_state = S_HADD;
            S_HADD:  n_state = (r_j == HORNER_LAST) ? S_AMUL : S_HMUL;
            S_AMUL:  n_state = S_ACC;
            S_ACC:   n_state = (CW'(r_w + 1'b1) == r_n) ? S_SAT : S_FETCH;
            S_SAT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_done       <= 1'b0;
            r_wave_count <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_SAT);
            if (cfg_wr) begin
                r_wave_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_acc && wr_ok) begin
            r_mem[AW'(i_req.wave_index)] <= '{i_req.amplitude, i_req.wavenumber_x,
                                              i_req.wavenumber_y, i_req.phase_offset};
        end
        if (r_state == S_FETCH) begin
            r_mem_q <= r_mem[r_w[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_ref_x <= i_req.ref_x;
                r_ref_y <= i_req.ref_y;
                r_sin   <= i_req.heading_sin;
                r_cos   <= i_req.heading_cos;
                r_lat   <= i_req.lateral_offset;
                r_n     <= (32'(r_wave_count) > 32'(MAX_WAVES)) ? CW'(MAX_WAVES)
                                                                : CW'(r_wave_count);
            end
            S_GY: r_gx <= sat35(gx_wide);
            S_GEND: begin
                r_gy  <= sat35(gy_wide);
                r_w   <= '0;
                r_sum <= '0;
            end
            S_KY: r_argx <= rnd16[47:0];
            S_PH: begin
                r_arg <= {{3{r_argx[47]}}, r_argx} + {{3{rnd16[47]}}, rnd16[47:0]}
                       + {{11{r_mem_q.phase_offset[31]}}, r_mem_q.phase_offset, 8'd0};
            end
            S_RSUB: r_rem <= rsub[28:0];
            S_FIX: begin
                if (r_rem < 0) begin
                    r_rem <= r_rem + TWO_PI_R;
                end else if (r_rem >= TWO_PI_R) begin
                    r_rem <= r_rem - TWO_PI_R;
                end
            end
            S_FOLD: r_r <= ({rem, 1'b0} > {1'b0, TWO_PI_Q24}) ? (TWO_PI_Q24 - rem) : rem;
            S_Y2: begin
                r_y2 <= rnd24[28:0];
                r_p  <= C10_Q30;
                r_j  <= '0;
            end
            S_HADD: begin
                r_p <= hsum[31:0];
                r_j <= r_j + 3'd1;
            end
            S_ACC: begin
                r_sum <= r_sum + SUM_W'(term30);
                r_w   <= CW'(r_w + 1'b1);
            end
            S_SAT: begin
                if (r_sum > SUM_MAX) begin
                    r_res <= '{32'sh7FFF_FFFF, 1'b1};
                end else if (r_sum < SUM_MIN) begin
                    r_res <= '{-32'sh8000_0000, 1'b1};
                end else begin
                    r_res <= '{r_sum[31:0], 1'b0};
                end
            end
            default: begin
            end
        endcase
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = !busy;
    assign o_done      = r_done;
    assign o_res       = r_res;

endmodule

// ----- rtl/cwsh_mul.sv -----
// ----------------------------------------------------------------------------
// cwsh_mul: shared multiplier
// Signed 32 x 32 multiply with a registered 64-bit product.
// ----------------------------------------------------------------------------
module cwsh_mul (
    input  logic                                i_clk,
    input  logic signed [cwsh_pkg::MUL_W-1:0]   i_op_a,
    input  logic signed [cwsh_pkg::MUL_W-1:0]   i_op_b,
    output logic signed [cwsh_pkg::PROD_W-1:0]  o_prod
);
    import cwsh_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_op_a) * PROD_W'(i_op_b);
    end

    assign o_prod = r_prod;

endmodule

// ----- rtl/cwsh_checker.sv -----
// ----------------------------------------------------------------------------
// cwsh_checker: port-level checks
// Request and result sequencing seen at the top-level ports.
// ----------------------------------------------------------------------------
module cwsh_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input cwsh_pkg::t_req  i_req,
    input logic            busy,
    input logic            o_done
);
    import cwsh_pkg::*;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.command == CMD_LOAD)) |=> (!busy && !o_done))
        else $error("load request caused busy or a result");

    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.command == CMD_EVAL)) |=> busy)
        else $error("evaluate request did not raise busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

endmodule

bind cosine_wave_sum_height cwsh_checker u_cwsh_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_req   (i_req),
    .busy    (busy),
    .o_done  (o_done)
);
